// ----- hdl/adl_pkg.sv -----
// shared types and constants for the array deque: sizes, op and status codes,
// the command word passed from the front end to the back end, back end states
// no dependencies
package adl_pkg;

	localparam int DEPTH    = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int LIVE_W   = IDX_W + 1;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int CMP_W    = (COUNT_W > LIVE_W) ? COUNT_W : LIVE_W;

	// command queue between front and back end
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QFILL_W = $clog2(QDEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_REAR  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_READOUT    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_WAS_EMPTY    = 2'd2,
		ST_BECAME_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       kind;
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_W-1:0]        count;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SHIFT,
		BK_SHIFT_FIN,
		BK_READ
	} back_state_t;

endpackage

// ----- hdl/adl_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module adl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/adl_front.sv -----
// front end: takes words on the start/busy handshake, drops unknown ops,
// and queues the rest as commands for the back end; uses adl_pkg
module adl_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [adl_pkg::OP_W-1:0]       op,
	input  logic signed [adl_pkg::VALUE_W-1:0] value,
	input  logic [adl_pkg::COUNT_W-1:0]    count,
	output adl_pkg::cmd_t                  cmd,
	output logic                           cmd_valid,
	input  logic                           cmd_take
);

	adl_pkg::cmd_t                 cmdq_q [adl_pkg::QDEPTH];
	logic [adl_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [adl_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [adl_pkg::QFILL_W-1:0]   fill_q;
	logic                          accept;
	logic                          known;
	logic                          push_en;
	logic                          pop_en;
	adl_pkg::cmd_t                 cmd_in;

	assign accept = start && !busy;
	assign busy   = (fill_q == adl_pkg::QFILL_W'(adl_pkg::QDEPTH));

	// classify: ops beyond read out are ignored entirely
	always_comb begin
		known = 1'b0;
		case (op)
			adl_pkg::OP_PUSH_REAR,
			adl_pkg::OP_PUSH_FRONT,
			adl_pkg::OP_POP_FRONT,
			adl_pkg::OP_POP_REAR,
			adl_pkg::OP_READOUT: known = 1'b1;
			default:             known = 1'b0;
		endcase
	end

	assign cmd_in.kind  = adl_pkg::op_t'(op);
	assign cmd_in.value = value;
	assign cmd_in.count = count;

	assign push_en   = accept && known;
	assign cmd_valid = (fill_q != '0);
	assign pop_en    = cmd_take && cmd_valid;
	assign cmd       = cmdq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			cmdq_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_en) begin
				if (wr_ptr_q == adl_pkg::QPTR_W'(adl_pkg::QDEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + adl_pkg::QPTR_W'(1);
				end
			end
			if (pop_en) begin
				if (rd_ptr_q == adl_pkg::QPTR_W'(adl_pkg::QDEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + adl_pkg::QPTR_W'(1);
				end
			end
			if (push_en && !pop_en) begin
				fill_q <= fill_q + adl_pkg::QFILL_W'(1);
			end else if (pop_en && !push_en) begin
				fill_q <= fill_q - adl_pkg::QFILL_W'(1);
			end
		end
	end

endmodule

// ----- hdl/adl_back.sv -----
// back end: executes queued commands against the entry ram, shifts entries
// for front pushes, streams read out words; uses adl_pkg and adl_ram
module adl_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  adl_pkg::cmd_t                      cmd,
	input  logic                               cmd_valid,
	output logic                               cmd_take,
	output logic                               strobe,
	output logic [adl_pkg::STATUS_W-1:0]       status,
	output logic signed [adl_pkg::VALUE_W-1:0] element,
	output logic                               last
);

	adl_pkg::back_state_t               state_q, state_d;
	logic [adl_pkg::IDX_W-1:0]          head_q, head_d;
	logic [adl_pkg::IDX_W-1:0]          tail_q, tail_d;
	logic                               empty_q, empty_d;
	logic [adl_pkg::IDX_W-1:0]          ptr_q, ptr_d;
	logic signed [adl_pkg::VALUE_W-1:0] value_q, value_d;

	logic                               strobe_q, strobe_d;
	adl_pkg::status_t                   status_q, status_d;
	logic signed [adl_pkg::VALUE_W-1:0] element_q, element_d;
	logic                               last_q, last_d;

	logic                               we;
	logic [adl_pkg::IDX_W-1:0]          waddr;
	logic [adl_pkg::VALUE_W-1:0]        wdata;
	logic [adl_pkg::IDX_W-1:0]          raddr;
	logic [adl_pkg::VALUE_W-1:0]        rdata;

	logic                               full;
	logic [adl_pkg::LIVE_W-1:0]         live;
	logic                               pop_all;

	adl_ram #(
		.WIDTH(adl_pkg::VALUE_W),
		.DEPTH(adl_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign full    = !empty_q && (tail_q == adl_pkg::IDX_W'(adl_pkg::DEPTH - 1));
	assign live    = {1'b0, tail_q} - {1'b0, head_q} + adl_pkg::LIVE_W'(1);
	assign pop_all = (adl_pkg::CMP_W'(cmd.count) >= adl_pkg::CMP_W'(live));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			adl_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						adl_pkg::OP_PUSH_FRONT: begin
							if (!empty_q && !full) begin
								state_d = adl_pkg::BK_SHIFT;
							end
						end
						adl_pkg::OP_READOUT: begin
							if (!empty_q) begin
								state_d = adl_pkg::BK_READ;
							end
						end
						default: ;
					endcase
				end
			end
			adl_pkg::BK_SHIFT: begin
				if (ptr_q == head_q) begin
					state_d = adl_pkg::BK_SHIFT_FIN;
				end
			end
			adl_pkg::BK_SHIFT_FIN: state_d = adl_pkg::BK_IDLE;
			adl_pkg::BK_READ: begin
				if (ptr_q == tail_q) begin
					state_d = adl_pkg::BK_IDLE;
				end
			end
			default: state_d = adl_pkg::BK_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		cmd_take  = 1'b0;
		we        = 1'b0;
		waddr     = ptr_q + adl_pkg::IDX_W'(1);
		wdata     = rdata;
		raddr     = ptr_q;
		head_d    = head_q;
		tail_d    = tail_q;
		empty_d   = empty_q;
		ptr_d     = ptr_q;
		value_d   = value_q;
		strobe_d  = 1'b0;
		status_d  = adl_pkg::ST_OK;
		element_d = '0;
		last_d    = 1'b0;
		case (state_q)
			adl_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					case (cmd.kind)
						adl_pkg::OP_PUSH_REAR, adl_pkg::OP_PUSH_FRONT: begin
							if (empty_q) begin
								we       = 1'b1;
								waddr    = '0;
								wdata    = cmd.value;
								head_d   = '0;
								tail_d   = '0;
								empty_d  = 1'b0;
								strobe_d = 1'b1;
								last_d   = 1'b1;
							end else if (full) begin
								strobe_d = 1'b1;
								status_d = adl_pkg::ST_FULL;
								last_d   = 1'b1;
							end else if (cmd.kind == adl_pkg::OP_PUSH_REAR) begin
								we       = 1'b1;
								waddr    = tail_q + adl_pkg::IDX_W'(1);
								wdata    = cmd.value;
								tail_d   = tail_q + adl_pkg::IDX_W'(1);
								strobe_d = 1'b1;
								last_d   = 1'b1;
							end else begin
								// start the shift from the rear entry downward
								raddr   = tail_q;
								ptr_d   = tail_q;
								value_d = cmd.value;
							end
						end
						adl_pkg::OP_POP_FRONT, adl_pkg::OP_POP_REAR: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
							if (empty_q) begin
								status_d = adl_pkg::ST_WAS_EMPTY;
							end else if (pop_all) begin
								status_d = adl_pkg::ST_BECAME_EMPTY;
								head_d   = '0;
								tail_d   = '0;
								empty_d  = 1'b1;
							end else if (cmd.kind == adl_pkg::OP_POP_FRONT) begin
								head_d = head_q + adl_pkg::IDX_W'(cmd.count);
							end else begin
								tail_d = tail_q - adl_pkg::IDX_W'(cmd.count);
							end
						end
						adl_pkg::OP_READOUT: begin
							if (empty_q) begin
								strobe_d = 1'b1;
								status_d = adl_pkg::ST_WAS_EMPTY;
								last_d   = 1'b1;
							end else begin
								raddr = head_q;
								ptr_d = head_q;
							end
						end
						default: ;
					endcase
				end
			end
			adl_pkg::BK_SHIFT: begin
				// entry at ptr arrives now, moves up one slot
				we    = 1'b1;
				waddr = ptr_q + adl_pkg::IDX_W'(1);
				wdata = rdata;
				if (ptr_q != head_q) begin
					raddr = ptr_q - adl_pkg::IDX_W'(1);
					ptr_d = ptr_q - adl_pkg::IDX_W'(1);
				end
			end
			adl_pkg::BK_SHIFT_FIN: begin
				we       = 1'b1;
				waddr    = head_q;
				wdata    = value_q;
				tail_d   = tail_q + adl_pkg::IDX_W'(1);
				strobe_d = 1'b1;
				last_d   = 1'b1;
			end
			adl_pkg::BK_READ: begin
				strobe_d  = 1'b1;
				element_d = rdata;
				last_d    = (ptr_q == tail_q);
				if (ptr_q != tail_q) begin
					raddr = ptr_q + adl_pkg::IDX_W'(1);
					ptr_d = ptr_q + adl_pkg::IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		value_q   <= value_d;
		status_q  <= status_d;
		element_q <= element_d;
		last_q    <= last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= adl_pkg::BK_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			empty_q  <= empty_d;
			strobe_q <= strobe_d;
		end
	end

	assign strobe  = strobe_q;
	assign status  = status_q;
	assign element = element_q;
	assign last    = last_q;

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty store with nonzero indices");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (head_q <= tail_q))
		else $error("head index past tail index");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q != adl_pkg::ST_OK) |-> (last_q && element_q == '0))
		else $error("error status word not final or carries data");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> (state_q == adl_pkg::BK_IDLE && cmd_valid))
		else $error("command taken while busy");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adl_pkg::BK_READ || state_q == adl_pkg::BK_SHIFT) |-> !empty_q)
		else $error("walking an empty store");

endmodule

// ----- hdl/array_deque_linear.sv -----
// top level of the array deque: front end, command queue and back end
// uses adl_pkg, adl_front, adl_back
//
// usage
//   input words are taken at a rising edge with start high and busy low;
//   op selects push rear, push front, pop front, pop rear or read out,
//   value is the word to push, count the number of entries to pop.
//   unknown op codes are dropped and give no result.
//   a two deep command queue lets start be taken while the back end works;
//   busy rises only when that queue is full.
//   results come out for one cycle each with strobe high; the receiver
//   cannot stall, so every strobed word must be taken when shown.
//   last marks the final result word of a command; element is zero except
//   for read out words.
// sequencing
//   push rear and pops: the accepted word waits in the command queue; the
//   back end takes and finishes it in idle and registers the result word.
//   push front: shift state, one ram read and write per cycle moving entries
//   up one slot from rear to front; shift fin writes the new front word.
//   read out: read state, one word per cycle from the registered ram read
//   port, front to rear, up to DEPTH words.
// reset
//   arst_n clears the indices, marks the store empty and empties the
//   command queue; the entry ram is not cleared and needs no sweep.
module array_deque_linear (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [adl_pkg::OP_W-1:0]            op,
	input  logic signed [adl_pkg::VALUE_W-1:0]  value,
	input  logic [adl_pkg::COUNT_W-1:0]         count,
	output logic                                strobe,
	output logic [adl_pkg::STATUS_W-1:0]        status,
	output logic signed [adl_pkg::VALUE_W-1:0]  element,
	output logic                                last
);

	// command word from the queue head and its handshake to the back end
	adl_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_take;

	// front end classifies and queues
	adl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.value    (value),
		.count    (count),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take)
	);

	// back end owns the store and drives the registered result word
	adl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.strobe   (strobe),
		.status   (status),
		.element  (element),
		.last     (last)
	);

endmodule

// ----- verif/array_deque_linear_chk.sv -----
`timescale 1ns / 100ps
// checker for the array deque: tracks the deque contents from accepted commands
// and compares every strobed result word in order; uses adl_pkg
module array_deque_linear_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [adl_pkg::OP_W-1:0]           op,
	input  logic signed [adl_pkg::VALUE_W-1:0] value,
	input  logic [adl_pkg::COUNT_W-1:0]        count,
	input  logic                               strobe,
	input  logic [adl_pkg::STATUS_W-1:0]       status,
	input  logic signed [adl_pkg::VALUE_W-1:0] element,
	input  logic                               last,
	output int                                 fails,
	output int                                 outstanding,
	output int                                 words_seen,
	output int                                 full_seen
);

	typedef struct {
		adl_pkg::status_t                   st;
		logic signed [adl_pkg::VALUE_W-1:0] elem;
		logic                               fin;
	} result_word_t;

	result_word_t pending_words[$];

	logic [adl_pkg::VALUE_W-1:0] slots [adl_pkg::DEPTH];
	logic [adl_pkg::IDX_W-1:0]   head_q;
	logic [adl_pkg::IDX_W-1:0]   tail_q;
	logic                        dq_empty;
	int                          n_fail;
	int                          n_words;
	int                          n_full;

	// advance the deque by one command and queue the words it should produce
	task automatic deque_model_step(input logic [adl_pkg::OP_W-1:0] o,
			input logic [adl_pkg::VALUE_W-1:0] v, input logic [adl_pkg::COUNT_W-1:0] c);
		adl_pkg::status_t st;
		int               live;
		int               i;
		case (o)
			adl_pkg::OP_PUSH_REAR, adl_pkg::OP_PUSH_FRONT: begin
				if (dq_empty) begin
					head_q   = '0;
					tail_q   = '0;
					slots[0] = v;
					dq_empty = 1'b0;
					st       = adl_pkg::ST_OK;
				end else if (tail_q == adl_pkg::IDX_W'(adl_pkg::DEPTH - 1)) begin
					st = adl_pkg::ST_FULL;
				end else begin
					if (o == adl_pkg::OP_PUSH_FRONT) begin
						for (i = int'(tail_q) + 1; i > int'(head_q); i--)
							slots[i] = slots[i-1];
						slots[head_q] = v;
					end else begin
						slots[int'(tail_q) + 1] = v;
					end
					tail_q = tail_q + 1'b1;
					st     = adl_pkg::ST_OK;
				end
				pending_words.push_back('{st, '0, 1'b1});
			end
			adl_pkg::OP_POP_FRONT, adl_pkg::OP_POP_REAR: begin
				if (dq_empty) begin
					st = adl_pkg::ST_WAS_EMPTY;
				end else begin
					live = int'(tail_q) - int'(head_q) + 1;
					if (int'(c) >= live) begin
						head_q   = '0;
						tail_q   = '0;
						dq_empty = 1'b1;
						st       = adl_pkg::ST_BECAME_EMPTY;
					end else begin
						if (o == adl_pkg::OP_POP_FRONT)
							head_q = head_q + c[adl_pkg::IDX_W-1:0];
						else
							tail_q = tail_q - c[adl_pkg::IDX_W-1:0];
						st = adl_pkg::ST_OK;
					end
				end
				pending_words.push_back('{st, '0, 1'b1});
			end
			adl_pkg::OP_READOUT: begin
				if (dq_empty) begin
					pending_words.push_back('{adl_pkg::ST_WAS_EMPTY, '0, 1'b1});
				end else begin
					for (i = int'(head_q); i <= int'(tail_q); i++)
						pending_words.push_back('{adl_pkg::ST_OK, slots[i],
							(i == int'(tail_q))});
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t w;
		if (!arst_n) begin
			pending_words.delete();
			head_q      = '0;
			tail_q      = '0;
			dq_empty    = 1'b1;
			n_fail      = 0;
			n_words     = 0;
			n_full      = 0;
			fails       <= 0;
			outstanding <= 0;
			words_seen  <= 0;
			full_seen   <= 0;
		end else begin
			if (strobe) begin
				n_words++;
				if (pending_words.size() == 0) begin
					$error("unexpected word: status %0d element %0d last %0b",
						status, element, last);
					n_fail++;
				end else begin
					w = pending_words.pop_front();
					if (w.st == adl_pkg::ST_FULL)
						n_full++;
					if (status !== w.st) begin
						$error("status: expected %0d, actual %0d", w.st, status);
						n_fail++;
					end
					if (element !== w.elem) begin
						$error("element: expected %0d, actual %0d", w.elem, element);
						n_fail++;
					end
					if (last !== w.fin) begin
						$error("last: expected %0b, actual %0b", w.fin, last);
						n_fail++;
					end
				end
			end
			if (start && !busy)
				deque_model_step(op, value, count);
			fails       <= n_fail;
			outstanding <= pending_words.size();
			words_seen  <= n_words;
			full_seen   <= n_full;
		end
	end

endmodule

// ----- verif/array_deque_linear_tb.sv -----
`timescale 1ns / 100ps
// top of the array deque testbench: clock, reset, command stimulus and verdict
// uses adl_pkg, array_deque_linear and array_deque_linear_chk
module array_deque_linear_tb;

	// op codes the block must drop without a result
	localparam logic [adl_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [adl_pkg::OP_W-1:0] OP_UNUSED_MID   = 3'd6;
	localparam logic [adl_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
	localparam int TOTAL_CMDS = 140;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_SETTLE} phase_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [adl_pkg::OP_W-1:0]           op_in;
	logic signed [adl_pkg::VALUE_W-1:0] value_in;
	logic [adl_pkg::COUNT_W-1:0]        count_in;
	logic                               strobe;
	logic [adl_pkg::STATUS_W-1:0]       status;
	logic signed [adl_pkg::VALUE_W-1:0] element;
	logic                               last;

	int  fails;
	int  outstanding;
	int  words_seen;
	int  full_seen;
	int  n_cmds;
	logic took;

	array_deque_linear DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.op      (op_in),
		.value   (value_in),
		.count   (count_in),
		.strobe  (strobe),
		.status  (status),
		.element (element),
		.last    (last)
	);

	array_deque_linear_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op_in),
		.value       (value_in),
		.count       (count_in),
		.strobe      (strobe),
		.status      (status),
		.element     (element),
		.last        (last),
		.fails       (fails),
		.outstanding (outstanding),
		.words_seen  (words_seen),
		.full_seen   (full_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// handshake seen at the rising edge, read back at the following falling edge
	initial took = 1'b0;
	always @(posedge clk)
		took <= start && !busy;

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// mostly extreme-free random words, with the corners now and then
	function automatic logic [adl_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// any count, for commands that ignore it
	function automatic logic [adl_pkg::COUNT_W-1:0] rand_count();
		return adl_pkg::COUNT_W'($urandom);
	endfunction

	// pop counts: mostly small so the deque keeps some depth, sometimes huge
	function automatic logic [adl_pkg::COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return adl_pkg::COUNT_W'($urandom_range(0, 3));
		else if (r < 17)
			return adl_pkg::COUNT_W'($urandom_range(4, 40));
		else
			return adl_pkg::COUNT_W'($urandom_range(41, 255));
	endfunction

	// gap between words: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// present one command word at a falling edge and hold it until taken;
	// returns at the falling edge after the accepting edge with start still high
	task automatic send_word(input logic [adl_pkg::OP_W-1:0] o,
			input logic [adl_pkg::VALUE_W-1:0] v, input logic [adl_pkg::COUNT_W-1:0] c);
		start    <= 1'b1;
		op_in    <= o;
		value_in <= v;
		count_in <= c;
		do
			@(negedge clk);
		while (!took);
		if (o <= adl_pkg::OP_READOUT)
			n_cmds++;
	endtask

	// drop start for the gap given by n, scrambling the idle fields meanwhile
	task automatic hold_off(input int n);
		start    <= 1'b0;
		op_in    <= adl_pkg::OP_W'($urandom);
		value_in <= $urandom;
		count_in <= rand_count();
		repeat (n) @(negedge clk);
	endtask

	// stop sending until every predicted word has come back
	task automatic drain_results();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_gap(input logic [adl_pkg::OP_W-1:0] o,
			input logic [adl_pkg::VALUE_W-1:0] v, input logic [adl_pkg::COUNT_W-1:0] c,
			input bit tight);
		int g;
		send_word(o, v, c);
		g = tight ? 0 : pick_gap();
		if (g > 0)
			hold_off(g);
	endtask

	initial begin
		phase_t                   ph;
		bit                       tight;
		bit                       first_phase;
		int                       n;
		int                       r;
		logic [adl_pkg::OP_W-1:0] o;

		arst_n   = 1'b0;
		start    = 1'b0;
		op_in    = '0;
		value_in = '0;
		count_in = '0;
		n_cmds   = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty store behavior first
		send_word(adl_pkg::OP_READOUT,    $urandom, rand_count());
		send_word(adl_pkg::OP_POP_FRONT,  $urandom, 8'd5);
		send_word(adl_pkg::OP_POP_REAR,   $urandom, 8'd0);
		// corner values from both ends
		send_word(adl_pkg::OP_PUSH_REAR,  32'h7FFF_FFFF, 8'hFF);
		send_word(adl_pkg::OP_PUSH_FRONT, 32'h8000_0000, 8'h00);
		send_word(adl_pkg::OP_PUSH_REAR,  32'h0000_0000, rand_count());
		send_word(adl_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, rand_count());
		send_word(adl_pkg::OP_READOUT,    $urandom, rand_count());
		// zero-count pops leave everything as it is, then single pops from each end
		send_word(adl_pkg::OP_POP_FRONT,  $urandom, 8'd0);
		send_word(adl_pkg::OP_POP_REAR,   $urandom, 8'd0);
		send_word(adl_pkg::OP_POP_FRONT,  $urandom, 8'd1);
		send_word(adl_pkg::OP_POP_REAR,   $urandom, 8'd1);
		send_word(adl_pkg::OP_READOUT,    $urandom, rand_count());
		// pop more than are live
		send_word(adl_pkg::OP_POP_FRONT,  $urandom, 8'd255);
		send_word(OP_UNUSED_FIRST,        $urandom, rand_count());
		// front push onto an empty store
		send_word(adl_pkg::OP_PUSH_FRONT, 32'd39, rand_count());
		send_word(OP_UNUSED_MID,          $urandom, rand_count());
		// pop exactly what is live
		send_word(adl_pkg::OP_POP_REAR,   $urandom, 8'd1);
		send_word(adl_pkg::OP_PUSH_REAR,  32'd1, rand_count());
		send_word(adl_pkg::OP_PUSH_REAR,  32'd2, rand_count());
		send_word(adl_pkg::OP_POP_FRONT,  $urandom, 8'd2);
		send_word(OP_UNUSED_LAST,         $urandom, rand_count());
		send_word(adl_pkg::OP_READOUT,    $urandom, rand_count());

		// let the directed part finish before the random phases
		drain_results();

		first_phase = 1'b1;
		while (n_cmds < TOTAL_CMDS) begin
			r = $urandom_range(0, 9);
			if (first_phase || r < 3)
				ph = PH_FILL;
			else if (r < 5)
				ph = PH_DRAIN;
			else if (r < 9)
				ph = PH_MIXED;
			else
				ph = PH_SETTLE;
			first_phase = 1'b0;
			tight = ($urandom_range(0, 3) == 0);
			case (ph)
				PH_FILL: begin
					// 28 to 36 pushes, often enough to reach the last slot and bounce off it
					n = $urandom_range(28, 36);
					repeat (n) begin
						o = $urandom_range(0, 1) ? adl_pkg::OP_PUSH_FRONT
							: adl_pkg::OP_PUSH_REAR;
						send_random_gap(o, pick_value(), rand_count(), tight);
					end
					send_random_gap(adl_pkg::OP_READOUT, $urandom, rand_count(), tight);
				end
				PH_DRAIN: begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						o = $urandom_range(0, 1) ? adl_pkg::OP_POP_FRONT
							: adl_pkg::OP_POP_REAR;
						send_random_gap(o, $urandom, pick_count(), tight);
					end
				end
				PH_MIXED: begin
					n = $urandom_range(4, 12);
					repeat (n) begin
						r = $urandom_range(0, 99);
						if (r < 30)
							o = adl_pkg::OP_PUSH_REAR;
						else if (r < 55)
							o = adl_pkg::OP_PUSH_FRONT;
						else if (r < 68)
							o = adl_pkg::OP_POP_FRONT;
						else if (r < 80)
							o = adl_pkg::OP_POP_REAR;
						else if (r < 95)
							o = adl_pkg::OP_READOUT;
						else
							o = adl_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST,
								OP_UNUSED_LAST));
						if (o == adl_pkg::OP_POP_FRONT || o == adl_pkg::OP_POP_REAR)
							send_random_gap(o, $urandom, pick_count(), tight);
						else
							send_random_gap(o, pick_value(), rand_count(), tight);
					end
				end
				default: begin
					// quiet point, then look at the whole store
					drain_results();
					send_random_gap(adl_pkg::OP_READOUT, $urandom, rand_count(), tight);
				end
			endcase
		end

		// everything sent: wait for the tail of results, then a readout's worth more
		drain_results();
		repeat (adl_pkg::DEPTH + 8) @(negedge clk);

		$display("summary: %0d commands, %0d result words checked, %0d pushes dropped on full",
			n_cmds, words_seen, full_seen);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
